// ===== design/csvtok_pkg.sv =====
package csvtok_pkg;

  localparam int FIELD_BUFFER_BYTES = 128;
  localparam logic [4:0] MAX_FIELDS = 5'd16;
  localparam logic [6:0] BYTE_LIMIT = 7'(FIELD_BUFFER_BYTES - 1);

  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam logic CMD_CHAR = 1'b0;

  localparam int MAX_RESULTS = 3;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    EV_BYTE  = 3'd0,
    EV_FEND  = 3'd1,
    EV_LOK   = 3'd2,
    EV_LBAD  = 3'd3,
    EV_DONE  = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
    logic [3:0] fnum;
    logic [6:0] fbytes;
  } result_t;

  // One accepted item expands into up to three results; cnt is never zero in the queue.
  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [MAX_RESULTS-1:0]   res;
  } bundle_t;

  function automatic result_t mk_res(ev_kind_t k, logic [7:0] d, logic [3:0] f,
                                     logic [6:0] b);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.fnum   = f;
    r.fbytes = b;
    return r;
  endfunction

endpackage

// ===== design/csv_record_tokenizer.sv =====
// CSV tokenizer: one character or end-of-input command per input beat.
// A result passes through a queue entry and then the output register before it reaches the output.
// Throughput: one item per cycle while the queue is not full; the output side delivers one
// result beat per cycle while pop is held, so each result of an item leaves as its own beat.
// A four-entry queue between parser and output decouples stalls on either side.
// Reset (rst_n low, synchronous) clears parser state, queue and output; expected_fields = 1.
module csv_record_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_cmd,
  input  logic [7:0] in_ch,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] out_event_kind,
  output logic [7:0] out_data_byte,
  output logic [3:0] out_field_number,
  output logic [6:0] out_field_bytes,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);
  import csvtok_pkg::*;

  logic    accept;
  logic    bundle_push;
  bundle_t bundle;
  logic    q_full;
  logic    head_valid;
  bundle_t head;
  logic    head_pop;
  result_t out_res;

  assign full = q_full;
  assign accept = push && !q_full;
  assign cfg_ready = 1'b1;

  csvtok_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_cmd      (in_cmd),
    .in_ch       (in_ch),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .bundle_push (bundle_push),
    .bundle      (bundle)
  );

  csvtok_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (bundle_push),
    .wr_data    (bundle),
    .q_full     (q_full),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  csvtok_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .out_res    (out_res),
    .out_last   (out_last_of_run)
  );

  assign out_event_kind   = out_res.kind;
  assign out_data_byte    = out_res.data;
  assign out_field_number = out_res.fnum;
  assign out_field_bytes  = out_res.fbytes;

endmodule

// ===== design/csvtok_front.sv =====
module csvtok_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 in_cmd,
  input  logic [7:0]           in_ch,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_data,
  output logic                 bundle_push,
  output csvtok_pkg::bundle_t  bundle
);
  import csvtok_pkg::*;

  logic       line_open_r, line_open_nxt;
  logic       skipping_r, skipping_nxt;
  logic       at_start_r, at_start_nxt;
  logic       quoted_r, quoted_nxt;
  logic       prev_quote_r, prev_quote_nxt;
  logic [6:0] bcnt_r, bcnt_nxt;
  logic [3:0] fcnt_r, fcnt_nxt;
  logic       finished_r, finished_nxt;
  logic [4:0] exp_r;

  logic [4:0] eff_fields;

  always_comb begin
    if (exp_r == 5'd0) begin
      eff_fields = 5'd1;
    end else if (exp_r > MAX_FIELDS) begin
      eff_fields = MAX_FIELDS;
    end else begin
      eff_fields = exp_r;
    end
  end

  always_comb begin
    logic       lo, sk, fs, q, pq, fin;
    logic [6:0] bc;
    logic [3:0] fc;
    logic [1:0] n;
    logic       do_end, line_end, do_store, skip_close, tail_done, sep;
    bundle_t    b;

    lo = line_open_r;
    sk = skipping_r;
    fs = at_start_r;
    q = quoted_r;
    pq = prev_quote_r;
    fin = finished_r;
    bc = bcnt_r;
    fc = fcnt_r;
    n = 2'd0;
    b = '0;
    do_end = 1'b0;
    line_end = 1'b0;
    do_store = 1'b0;
    skip_close = 1'b0;
    tail_done = 1'b0;
    sep = (in_ch == CH_COMMA) || (in_ch == CH_NEWLINE);

    // Classify the item.
    if (fin) begin
      tail_done = 1'b1;
    end else if (in_cmd != CMD_CHAR) begin
      if (lo && !sk) begin
        do_end = 1'b1;
        line_end = 1'b1;
      end else if (lo) begin
        skip_close = 1'b1;
      end
      tail_done = 1'b1;
      fin = 1'b1;
    end else if (lo || in_ch != CH_NEWLINE) begin
      if (!lo) begin
        lo = 1'b1;
        fc = 4'd0;
        fs = 1'b1;
        q = 1'b0;
        pq = 1'b0;
        bc = 7'd0;
      end
      if (sk) begin
        if (in_ch == CH_NEWLINE) begin
          skip_close = 1'b1;
        end
      end else if (in_ch == CH_NUL) begin
        do_end = 1'b1;
      end else if (fs && in_ch == CH_QUOTE) begin
        fs = 1'b0;
        q = 1'b1;
        pq = 1'b0;
      end else begin
        fs = 1'b0;
        if (q) begin
          if (pq) begin
            if (sep) begin
              do_end = 1'b1;
              line_end = (in_ch == CH_NEWLINE);
            end else begin
              do_store = 1'b1;
              pq = 1'b0;
            end
          end else if (in_ch == CH_QUOTE) begin
            pq = 1'b1;
          end else begin
            do_store = 1'b1;
          end
        end else if (sep) begin
          do_end = 1'b1;
          line_end = (in_ch == CH_NEWLINE);
        end else begin
          do_store = 1'b1;
          pq = (in_ch == CH_QUOTE) && !pq;
        end
      end
    end

    // Expand into results, in the order they leave the block.
    if (do_store && bc < BYTE_LIMIT) begin
      bc = bc + 7'd1;
      b.res[n] = mk_res(EV_BYTE, in_ch, fc, bc);
      n = n + 2'd1;
    end
    if (do_end) begin
      b.res[n] = mk_res(EV_FEND, 8'd0, fc, bc);
      n = n + 2'd1;
      fs = 1'b1;
      q = 1'b0;
      pq = 1'b0;
      bc = 7'd0;
      if ({1'b0, fc} + 5'd1 >= eff_fields) begin
        if (line_end) begin
          b.res[n] = mk_res(EV_LOK, 8'd0, fc, 7'd0);
          n = n + 2'd1;
          lo = 1'b0;
          sk = 1'b0;
          fc = 4'd0;
        end else begin
          sk = 1'b1;
        end
      end else if (line_end) begin
        b.res[n] = mk_res(EV_LBAD, 8'd0, fc, 7'd0);
        n = n + 2'd1;
        lo = 1'b0;
        sk = 1'b0;
        fc = 4'd0;
      end else begin
        fc = fc + 4'd1;
      end
    end
    if (skip_close) begin
      b.res[n] = mk_res(EV_LBAD, 8'd0, fc, 7'd0);
      n = n + 2'd1;
      lo = 1'b0;
      sk = 1'b0;
      fc = 4'd0;
      fs = 1'b1;
      q = 1'b0;
      pq = 1'b0;
      bc = 7'd0;
    end
    if (tail_done) begin
      b.res[n] = mk_res(EV_DONE, 8'd0, 4'd0, 7'd0);
      n = n + 2'd1;
    end
    b.cnt = n;

    line_open_nxt = lo;
    skipping_nxt = sk;
    at_start_nxt = fs;
    quoted_nxt = q;
    prev_quote_nxt = pq;
    bcnt_nxt = bc;
    fcnt_nxt = fc;
    finished_nxt = fin;
    bundle = b;
    bundle_push = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_open_r <= 1'b0;
      skipping_r <= 1'b0;
      at_start_r <= 1'b1;
      quoted_r <= 1'b0;
      prev_quote_r <= 1'b0;
      bcnt_r <= 7'd0;
      fcnt_r <= 4'd0;
      finished_r <= 1'b0;
    end else if (accept) begin
      line_open_r <= line_open_nxt;
      skipping_r <= skipping_nxt;
      at_start_r <= at_start_nxt;
      quoted_r <= quoted_nxt;
      prev_quote_r <= prev_quote_nxt;
      bcnt_r <= bcnt_nxt;
      fcnt_r <= fcnt_nxt;
      finished_r <= finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= 5'd1;
    end else if (cfg_we) begin
      exp_r <= cfg_data;
    end
  end

endmodule

// ===== design/csvtok_queue.sv =====
module csvtok_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  csvtok_pkg::bundle_t  wr_data,
  output logic                 q_full,
  output logic                 head_valid,
  output csvtok_pkg::bundle_t  head,
  input  logic                 head_pop
);
  import csvtok_pkg::*;

  bundle_t          mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r, cnt_nxt;

  assign q_full = (cnt_r == (QAW+1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !(head_pop && head_valid)) begin
      cnt_nxt = cnt_r + (QAW+1)'(1);
    end else if (!wr_en && head_pop && head_valid) begin
      cnt_nxt = cnt_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (head_pop && head_valid) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/csvtok_back.sv =====
module csvtok_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  csvtok_pkg::bundle_t  head,
  output logic                 head_pop,
  output logic                 empty,
  input  logic                 pop,
  output csvtok_pkg::result_t  out_res,
  output logic                 out_last
);
  import csvtok_pkg::*;

  logic [1:0] idx_r;
  logic       ovld_r;
  result_t    ores_r;
  logic       olast_r;
  logic       load, is_last;

  // The output register refills in the same cycle its beat is taken.
  assign load = head_valid && (!ovld_r || pop);
  assign is_last = (idx_r == head.cnt - 2'd1);
  assign head_pop = load && is_last;

  assign empty = !ovld_r;
  assign out_res = ores_r;
  assign out_last = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      ovld_r <= 1'b0;
    end else begin
      if (load) begin
        ovld_r <= 1'b1;
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ores_r <= head.res[idx_r];
      olast_r <= is_last;
    end
  end

endmodule

// ===== verif/tb_csv_record_tokenizer.sv =====
`timescale 1ns / 100ps

module tb_csv_record_tokenizer;
  import csvtok_pkg::*;

  localparam logic CMD_END = 1'b1;
  localparam int   IDLE_LIMIT = 2000;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   HOLD_CYCLES = 90;

  typedef struct {
    logic       cmd;
    logic [7:0] ch;
  } csv_char_t;

  typedef struct {
    ev_kind_t   kind;
    logic [7:0] data;
    logic [3:0] fnum;
    logic [6:0] fbytes;
    logic       last;
  } token_event_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic       in_cmd = CMD_CHAR;
  logic [7:0] in_ch = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] out_event_kind;
  logic [7:0] out_data_byte;
  logic [3:0] out_field_number;
  logic [6:0] out_field_bytes;
  logic       out_last_of_run;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = 5'd0;

  csv_record_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_cmd           (in_cmd),
    .in_ch            (in_ch),
    .empty            (empty),
    .pop              (pop),
    .out_event_kind   (out_event_kind),
    .out_data_byte    (out_data_byte),
    .out_field_number (out_field_number),
    .out_field_bytes  (out_field_bytes),
    .out_last_of_run  (out_last_of_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  csv_char_t    char_stream[$];
  token_event_t token_events[$];
  token_event_t step_events[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int queued_chars = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;

  // Tokenizer state as the block should hold it.
  int         fields_per_line = 1;
  logic       line_open = 1'b0;
  logic       skipping = 1'b0;
  logic       at_start = 1'b1;
  logic       quoted = 1'b0;
  logic       prev_quote = 1'b0;
  logic [6:0] byte_count = 7'd0;
  logic [3:0] field_count = 4'd0;
  logic       finished = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note_event(ev_kind_t k, logic [7:0] d, logic [3:0] f,
                                     logic [6:0] b);
    token_event_t e;
    e.kind   = k;
    e.data   = d;
    e.fnum   = f;
    e.fbytes = b;
    e.last   = 1'b0;
    step_events.push_back(e);
  endfunction

  function automatic void start_field();
    at_start   = 1'b1;
    quoted     = 1'b0;
    prev_quote = 1'b0;
    byte_count = 7'd0;
  endfunction

  function automatic void close_record();
    line_open   = 1'b0;
    skipping    = 1'b0;
    field_count = 4'd0;
    start_field();
  endfunction

  function automatic void finish_field(logic line_end);
    note_event(EV_FEND, 8'h00, field_count, byte_count);
    start_field();
    if (int'(field_count) + 1 >= fields_per_line) begin
      if (line_end) begin
        note_event(EV_LOK, 8'h00, field_count, 7'd0);
        close_record();
      end else begin
        // Separator after the last expected field: the line has too many fields.
        skipping = 1'b1;
      end
    end else if (line_end) begin
      note_event(EV_LBAD, 8'h00, field_count, 7'd0);
      close_record();
    end else begin
      field_count = field_count + 4'd1;
    end
  endfunction

  function automatic void keep_byte(logic [7:0] c);
    if (byte_count < BYTE_LIMIT) begin
      byte_count = byte_count + 7'd1;
      note_event(EV_BYTE, c, field_count, byte_count);
    end
  endfunction

  function automatic void tokenize_item(csv_char_t it);
    logic sep;
    step_events.delete();
    if (finished) begin
      note_event(EV_DONE, 8'h00, 4'd0, 7'd0);
    end else if (it.cmd == CMD_END) begin
      if (line_open && !skipping) finish_field(1'b1);
      if (line_open) begin
        note_event(EV_LBAD, 8'h00, field_count, 7'd0);
        close_record();
      end
      note_event(EV_DONE, 8'h00, 4'd0, 7'd0);
      finished = 1'b1;
    end else if (line_open || it.ch != CH_NEWLINE) begin
      if (!line_open) begin
        line_open   = 1'b1;
        field_count = 4'd0;
        start_field();
      end
      if (skipping) begin
        if (it.ch == CH_NEWLINE) begin
          note_event(EV_LBAD, 8'h00, field_count, 7'd0);
          close_record();
        end
      end else if (it.ch == CH_NUL) begin
        finish_field(1'b0);
      end else if (at_start && it.ch == CH_QUOTE) begin
        at_start   = 1'b0;
        quoted     = 1'b1;
        prev_quote = 1'b0;
      end else begin
        sep = (it.ch == CH_COMMA) || (it.ch == CH_NEWLINE);
        at_start = 1'b0;
        if (quoted) begin
          if (prev_quote) begin
            if (sep) begin
              finish_field(it.ch == CH_NEWLINE);
            end else begin
              keep_byte(it.ch);
              prev_quote = 1'b0;
            end
          end else if (it.ch == CH_QUOTE) begin
            prev_quote = 1'b1;
          end else begin
            keep_byte(it.ch);
          end
        end else if (sep) begin
          finish_field(it.ch == CH_NEWLINE);
        end else begin
          keep_byte(it.ch);
          prev_quote = (it.ch == CH_QUOTE) && !prev_quote;
        end
      end
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) token_events.push_back(step_events[i]);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: bursts of random length, often separated by random gaps (none while reading is held).
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        tokenize_item(char_stream[0]);
        void'(char_stream.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (hold_left == 0 && $urandom_range(0, 3) != 0) gap_left = $urandom_range(1, 10);
      end
      if (gap_left == 0 && char_stream.size() > 0) begin
        push   <= 1'b1;
        in_cmd <= char_stream[0].cmd;
        in_ch  <= char_stream[0].ch;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each result beat and stalls at a rate that changes now and then.
  always @(posedge clk) begin
    token_event_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (token_events.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                   $time, out_event_kind, out_data_byte);
          mismatches++;
        end else begin
          want = token_events.pop_front();
          check_field("event_kind", 8'(want.kind), 8'(out_event_kind));
          check_field("data_byte", want.data, out_data_byte);
          check_field("field_number", 8'(want.fnum), 8'(out_field_number));
          check_field("field_bytes", 8'(want.fbytes), 8'(out_field_bytes));
          check_field("last_of_run", 8'(want.last), 8'(out_last_of_run));
        end
      end
      rx_cycle++;
      if (rx_cycle % 40 == 0) rx_mode = $urandom_range(0, 3);
      pop <= (hold_left == 0) && (rx_mode == 0 || $urandom_range(0, rx_mode) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic void add_char(logic [7:0] c);
    csv_char_t it;
    it.cmd = CMD_CHAR;
    it.ch  = c;
    char_stream.push_back(it);
    queued_chars++;
  endfunction

  function automatic void add_end();
    csv_char_t it;
    it.cmd = CMD_END;
    it.ch  = 8'($urandom_range(0, 255));
    char_stream.push_back(it);
    queued_chars++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void add_field(int len, logic quote_it);
    logic [7:0] c;
    if (quote_it) add_char(CH_QUOTE);
    for (int i = 0; i < len; i++) begin
      if (quote_it) begin
        case ($urandom_range(0, 5))
          0: c = CH_COMMA;
          1: c = CH_NEWLINE;
          2: c = CH_QUOTE;
          default: c = 8'($urandom_range(1, 255));
        endcase
        add_char(c);
        // Inside quotes a quote character is written twice.
        if (c == CH_QUOTE) add_char(CH_QUOTE);
      end else begin
        do c = 8'($urandom_range(1, 255));
        while (c == CH_COMMA || c == CH_NEWLINE || (i == 0 && c == CH_QUOTE));
        add_char(c);
      end
    end
    if (quote_it) add_char(CH_QUOTE);
  endfunction

  function automatic void add_line(int nfields);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) add_char(($urandom_range(0, 7) == 0) ? CH_NUL : CH_COMMA);
      add_field($urandom_range(0, 3), $urandom_range(0, 2) == 0);
    end
    add_char(CH_NEWLINE);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: add_char(CH_QUOTE);
        1: add_char(CH_COMMA);
        2: add_char(CH_NEWLINE);
        3: add_char(CH_NUL);
        default: add_char(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  task automatic wait_idle();
    while (char_stream.size() > 0 || token_events.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_fields(logic [4:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (value == 5'd0) fields_per_line = 1;
    else if (value > MAX_FIELDS) fields_per_line = int'(MAX_FIELDS);
    else fields_per_line = int'(value);
  endtask

  initial begin
    logic [4:0] plan[8];
    int n;
    plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd5, 5'd17, 5'd2};
    plan[7] = 5'($urandom_range(0, 31));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty line, quoted field with a doubled quote, too many fields,
    // too few fields with a 0xFF byte, and a zero byte as separator.
    write_fields(5'd2);
    @(negedge clk);
    add_char(CH_NEWLINE);
    add_text("a,\"b\"\"c\"\n");
    add_text("x,y,z\n");
    add_char(8'hFF);
    add_char(CH_NEWLINE);
    add_char("q");
    add_char(CH_NUL);
    add_text("r\n");

    foreach (plan[p]) begin
      wait_idle();
      write_fields(plan[p]);
      @(negedge clk);
      queued_chars = 0;
      // Stop reading for a while so that the block fills up and pushes back.
      if (p == 2) hold_req = 1'b1;
      // One field longer than the buffer, so that its tail is dropped.
      if (p == 4) begin
        add_field(135, 1'b0);
        add_char(CH_NEWLINE);
      end
      while (queued_chars < 12) begin
        case ($urandom_range(0, 9))
          0: add_noise($urandom_range(1, 6));
          1: add_char(CH_NEWLINE);
          2: begin
            add_char(CH_QUOTE);
            add_noise($urandom_range(1, 4));
            add_char(CH_NEWLINE);
          end
          7: add_line((fields_per_line > 1) ? fields_per_line - 1 : 1);
          8: add_line(fields_per_line + 1);
          default: add_line(fields_per_line);
        endcase
      end
    end

    // End of input arrives with a line in some random state; later items only see done.
    wait_idle();
    write_fields(5'($urandom_range(0, 31)));
    @(negedge clk);
    add_line(fields_per_line);
    n = $urandom_range(0, 3);
    repeat (n) begin
      add_field($urandom_range(0, 3), $urandom_range(0, 1) == 1);
      add_char(CH_COMMA);
    end
    if ($urandom_range(0, 1) == 1) add_field($urandom_range(1, 3), 1'b0);
    if ($urandom_range(0, 1) == 1) add_char(CH_QUOTE);
    add_end();
    add_char(8'($urandom_range(0, 255)));
    add_char(CH_NEWLINE);
    add_end();

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/csvtok_pkg.sv
design/csvtok_front.sv
design/csvtok_queue.sv
design/csvtok_back.sv
design/csv_record_tokenizer.sv
verif/tb_csv_record_tokenizer.sv
